// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, codes and helper functions for the tokenizer front end,
// the result queue and the result emitter.
// ----------------------------------------------------------------------------
package stt_pkg;

	typedef enum logic [3:0] {
		SM_IDLE,
		SM_SLASH,
		SM_LINE,
		SM_BLOCK,
		SM_BSTAR,
		SM_NUM,
		SM_IDENT,
		SM_KEY
	} scan_mode_t;

	typedef enum logic [3:0] {
		TK_KEYWORD = 4'd0,
		TK_LBRACE  = 4'd1,
		TK_RBRACE  = 4'd2,
		TK_LPAREN  = 4'd3,
		TK_RPAREN  = 4'd4,
		TK_ASSIGN  = 4'd5,
		TK_PLUS    = 4'd6,
		TK_MINUS   = 4'd7,
		TK_NUMBER  = 4'd8,
		TK_IDENT   = 4'd9
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNRECOGNIZED = 2'd1,
		ST_UNCLOSED     = 2'd2,
		ST_NUL          = 2'd3
	} status_t;

	typedef enum logic {
		RK_TOKEN  = 1'b0,
		RK_STATUS = 1'b1
	} result_kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ASSIGN = 8'h3D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_F      = 8'h66;

	localparam logic [3:0]  KW_LEN      = 4'd8;
	localparam logic [16:0] LC_MAX      = 17'h10000;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned RES_PER_ITEM = 3;

	typedef struct packed {
		result_kind_t result_kind;
		tok_kind_t    token_kind;
		logic [15:0]  start_offset;
		logic [16:0]  token_length;
		status_t      status;
		logic [16:0]  error_line;
		logic [16:0]  error_column;
	} result_t;

	typedef struct packed {
		result_t [RES_PER_ITEM-1:0] res;
		logic [1:0]                 cnt;
	} bundle_t;

	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h66;
			3'd1: ch = 8'h75;
			3'd2: ch = 8'h6E;
			3'd3: ch = 8'h63;
			3'd4: ch = 8'h74;
			3'd5: ch = 8'h69;
			3'd6: ch = 8'h6F;
			3'd7: ch = 8'h6E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] ch);
		return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
	endfunction

	function automatic result_t make_token(input tok_kind_t kind, input logic [15:0] start,
			input logic [16:0] len);
		result_t r;
		r.result_kind  = RK_TOKEN;
		r.token_kind   = kind;
		r.start_offset = start;
		r.token_length = len;
		r.status       = ST_OK;
		r.error_line   = 17'd0;
		r.error_column = 17'd0;
		return r;
	endfunction

	function automatic result_t make_status(input status_t st, input logic [16:0] ln,
			input logic [16:0] col);
		result_t r;
		r.result_kind  = RK_STATUS;
		r.token_kind   = TK_KEYWORD;
		r.start_offset = 16'd0;
		r.token_length = 17'd0;
		r.status       = st;
		r.error_line   = ln;
		r.error_column = col;
		return r;
	endfunction

endpackage

// ===== design/stt_scanner.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies one text byte per accepted transaction, updates the scan state
// and produces the bundle of up to three results that the byte causes.
// ----------------------------------------------------------------------------
module stt_scanner #(
	parameter int unsigned TEXT_BYTES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      text_byte,
	input  logic            end_of_text,
	output logic            bundle_valid,
	output stt_pkg::bundle_t bundle
);

	localparam int unsigned LEN_MAX_I = (TEXT_BYTES < 65536) ? TEXT_BYTES : 65536;
	localparam logic [16:0] LEN_MAX   = 17'(LEN_MAX_I);
	localparam logic [15:0] OFF_MAX   = 16'(LEN_MAX_I - 1);

	stt_pkg::scan_mode_t mode_q, mode_n;
	logic [3:0]  kw_q, kw_n;
	logic [15:0] tok_start_q, tok_start_n;
	logic [16:0] tok_size_q, tok_size_n;
	logic [15:0] offset_q, offset_n;
	logic [16:0] line_q, line_n;
	logic [16:0] col_q, col_n;
	logic [16:0] opl_q, opl_n;
	logic [16:0] opc_q, opc_n;
	logic        halted_q, halted_n;

	logic [16:0] size_grown;
	logic        alnum;
	logic        do_idle;

	logic                 pend_v;
	stt_pkg::tok_kind_t   pend_kind;
	logic [16:0]          pend_len;
	logic                 step_v;
	stt_pkg::result_t     step_res;

	assign alnum      = stt_pkg::is_digit(text_byte) || stt_pkg::is_letter(text_byte);
	assign size_grown = (tok_size_q < LEN_MAX) ? tok_size_q + 17'd1 : tok_size_q;

	always_comb begin
		mode_n      = mode_q;
		kw_n        = kw_q;
		tok_start_n = tok_start_q;
		tok_size_n  = tok_size_q;
		offset_n    = offset_q;
		line_n      = line_q;
		col_n       = col_q;
		opl_n       = opl_q;
		opc_n       = opc_q;
		halted_n    = halted_q;
		do_idle     = 1'b0;
		pend_v      = 1'b0;
		pend_kind   = stt_pkg::TK_IDENT;
		pend_len    = tok_size_q;
		step_v      = 1'b0;
		step_res    = stt_pkg::make_status(stt_pkg::ST_OK, 17'd0, 17'd0);
		if (!halted_q) begin
			unique case (mode_q)
				stt_pkg::SM_SLASH: begin
					if (text_byte == stt_pkg::CH_SLASH) begin
						mode_n = stt_pkg::SM_LINE;
					end else if (text_byte == stt_pkg::CH_STAR) begin
						mode_n = stt_pkg::SM_BSTAR;
					end else begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_status(stt_pkg::ST_UNRECOGNIZED, opl_q, opc_q);
						halted_n = 1'b1;
						mode_n   = stt_pkg::SM_IDLE;
					end
				end
				stt_pkg::SM_LINE: begin
					if (text_byte == stt_pkg::CH_NL) begin
						mode_n = stt_pkg::SM_IDLE;
					end
				end
				stt_pkg::SM_BLOCK, stt_pkg::SM_BSTAR: begin
					if (mode_q == stt_pkg::SM_BSTAR && text_byte == stt_pkg::CH_SLASH) begin
						mode_n = stt_pkg::SM_IDLE;
					end else if (text_byte == stt_pkg::CH_STAR) begin
						mode_n = stt_pkg::SM_BSTAR;
					end else begin
						mode_n = stt_pkg::SM_BLOCK;
					end
				end
				stt_pkg::SM_NUM: begin
					if (stt_pkg::is_digit(text_byte)) begin
						tok_size_n = size_grown;
					end else begin
						pend_v    = 1'b1;
						pend_kind = stt_pkg::TK_NUMBER;
						do_idle   = 1'b1;
					end
				end
				stt_pkg::SM_IDENT: begin
					if (alnum) begin
						tok_size_n = size_grown;
					end else begin
						pend_v  = 1'b1;
						do_idle = 1'b1;
					end
				end
				stt_pkg::SM_KEY: begin
					if (!kw_q[3] && text_byte == stt_pkg::kw_char(kw_q[2:0])) begin
						kw_n       = kw_q + 4'd1;
						tok_size_n = size_grown;
						if (kw_n == stt_pkg::KW_LEN) begin
							pend_v    = 1'b1;
							pend_kind = stt_pkg::TK_KEYWORD;
							pend_len  = size_grown;
							mode_n    = stt_pkg::SM_IDLE;
						end
					end else if (alnum) begin
						tok_size_n = size_grown;
						mode_n     = stt_pkg::SM_IDENT;
					end else begin
						pend_v  = 1'b1;
						do_idle = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			if (do_idle) begin
				mode_n = stt_pkg::SM_IDLE;
				unique case (text_byte)
					stt_pkg::CH_SPACE, stt_pkg::CH_NL: begin
					end
					stt_pkg::CH_LBRACE: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_LBRACE, offset_q, 17'd1);
					end
					stt_pkg::CH_RBRACE: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_RBRACE, offset_q, 17'd1);
					end
					stt_pkg::CH_LPAREN: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_LPAREN, offset_q, 17'd1);
					end
					stt_pkg::CH_RPAREN: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_RPAREN, offset_q, 17'd1);
					end
					stt_pkg::CH_ASSIGN: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_ASSIGN, offset_q, 17'd1);
					end
					stt_pkg::CH_PLUS: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_PLUS, offset_q, 17'd1);
					end
					stt_pkg::CH_MINUS: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_token(stt_pkg::TK_MINUS, offset_q, 17'd1);
					end
					stt_pkg::CH_SLASH: begin
						mode_n = stt_pkg::SM_SLASH;
						opl_n  = line_q;
						opc_n  = col_q;
					end
					stt_pkg::CH_NUL: begin
						step_v   = 1'b1;
						step_res = stt_pkg::make_status(stt_pkg::ST_NUL, line_q, col_q);
						halted_n = 1'b1;
					end
					default: begin
						if (alnum) begin
							tok_start_n = offset_q;
							tok_size_n  = 17'd1;
							if (text_byte == stt_pkg::CH_F) begin
								mode_n = stt_pkg::SM_KEY;
								kw_n   = 4'd1;
							end else if (stt_pkg::is_digit(text_byte)) begin
								mode_n = stt_pkg::SM_NUM;
							end else begin
								mode_n = stt_pkg::SM_IDENT;
							end
						end else begin
							step_v   = 1'b1;
							step_res = stt_pkg::make_status(stt_pkg::ST_UNRECOGNIZED,
								line_q, col_q);
							halted_n = 1'b1;
						end
					end
				endcase
			end

			if (offset_q < OFF_MAX) begin
				offset_n = offset_q + 16'd1;
			end
			if (text_byte == stt_pkg::CH_NL) begin
				if (line_q < stt_pkg::LC_MAX) begin
					line_n = line_q + 17'd1;
				end
				col_n = 17'd1;
			end else if (col_q < stt_pkg::LC_MAX) begin
				col_n = col_q + 17'd1;
			end
		end
	end

	logic             eot_tok_v;
	stt_pkg::result_t eot_tok;
	logic             eot_stat_v;
	stt_pkg::result_t eot_stat;
	logic [1:0]       n;
	stt_pkg::bundle_t bnd;

	always_comb begin
		eot_tok_v  = end_of_text && !halted_n &&
			(mode_n == stt_pkg::SM_NUM || mode_n == stt_pkg::SM_IDENT ||
			mode_n == stt_pkg::SM_KEY);
		eot_tok    = stt_pkg::make_token(
			(mode_n == stt_pkg::SM_NUM) ? stt_pkg::TK_NUMBER : stt_pkg::TK_IDENT,
			tok_start_n, tok_size_n);
		eot_stat_v = end_of_text && !halted_n;
		if (mode_n == stt_pkg::SM_SLASH) begin
			eot_stat = stt_pkg::make_status(stt_pkg::ST_UNRECOGNIZED, opl_n, opc_n);
		end else if (mode_n == stt_pkg::SM_BLOCK || mode_n == stt_pkg::SM_BSTAR) begin
			eot_stat = stt_pkg::make_status(stt_pkg::ST_UNCLOSED, opl_n, opc_n);
		end else begin
			eot_stat = stt_pkg::make_status(stt_pkg::ST_OK, 17'd0, 17'd0);
		end

		bnd = '0;
		n   = 2'd0;
		if (pend_v) begin
			bnd.res[n] = stt_pkg::make_token(pend_kind, tok_start_q, pend_len);
			n          = n + 2'd1;
		end
		if (step_v && n != 2'd3) begin
			bnd.res[n] = step_res;
			n          = n + 2'd1;
		end
		if (eot_tok_v && n != 2'd3) begin
			bnd.res[n] = eot_tok;
			n          = n + 2'd1;
		end
		if (eot_stat_v && n != 2'd3) begin
			bnd.res[n] = eot_stat;
			n          = n + 2'd1;
		end
		bnd.cnt = n;
	end

	assign bundle       = bnd;
	assign bundle_valid = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= stt_pkg::SM_IDLE;
			kw_q        <= 4'd0;
			tok_start_q <= 16'd0;
			tok_size_q  <= 17'd0;
			offset_q    <= 16'd0;
			line_q      <= 17'd1;
			col_q       <= 17'd1;
			opl_q       <= 17'd1;
			opc_q       <= 17'd1;
			halted_q    <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q      <= stt_pkg::SM_IDLE;
				kw_q        <= 4'd0;
				tok_start_q <= 16'd0;
				tok_size_q  <= 17'd0;
				offset_q    <= 16'd0;
				line_q      <= 17'd1;
				col_q       <= 17'd1;
				opl_q       <= 17'd1;
				opc_q       <= 17'd1;
				halted_q    <= 1'b0;
			end else begin
				mode_q      <= mode_n;
				kw_q        <= kw_n;
				tok_start_q <= tok_start_n;
				tok_size_q  <= tok_size_n;
				offset_q    <= offset_n;
				line_q      <= line_n;
				col_q       <= col_n;
				opl_q       <= opl_n;
				opc_q       <= opc_n;
				halted_q    <= halted_n;
			end
		end
	end

endmodule

// ===== design/stt_queue.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Short first-in first-out queue of result bundles between the front end
// and the emitter.
// ----------------------------------------------------------------------------
module stt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  stt_pkg::bundle_t wr_data,
	input  logic             rd_en,
	output stt_pkg::bundle_t head,
	output logic             q_empty,
	output logic             q_full
);

	stt_pkg::bundle_t                  mem_q [stt_pkg::QUEUE_DEPTH];
	logic [stt_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [stt_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [stt_pkg::QPTR_W:0]          count_q;

	assign head    = mem_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == (stt_pkg::QPTR_W + 1)'(stt_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + (stt_pkg::QPTR_W)'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + (stt_pkg::QPTR_W)'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (stt_pkg::QPTR_W + 1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (stt_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// ===== design/stt_emitter.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result emitter
// Takes the bundle at the head of the queue apart into single results and
// holds each one in the output register until its transaction completes.
// ----------------------------------------------------------------------------
module stt_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  stt_pkg::bundle_t head,
	input  logic             q_empty,
	output logic             deq,
	input  logic             pop,
	output logic             empty,
	output stt_pkg::result_t res,
	output logic             last_result
);

	logic             out_valid_q;
	stt_pkg::result_t out_q;
	logic             last_q;
	logic [1:0]       idx_q;
	logic             load;
	logic             idx_last;

	assign load     = (!out_valid_q || pop) && !q_empty;
	assign idx_last = (idx_q == head.cnt - 2'd1);
	assign deq      = load && idx_last;

	assign empty       = !out_valid_q;
	assign res         = out_q;
	assign last_result = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= head.res[idx_q];
			last_q <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer
// The first result of a byte is written to the queue and then loaded into the output
// register, which drives the output ports.
// One byte per cycle while full is low; results leave the output register one per cycle
// while the receiver pops, so a byte that causes k results holds the output side until
// all k have left, and a four-bundle queue absorbs the difference until full rises.
// Reset clears the scan state, the queue pointers and the output register valid.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
	parameter int unsigned TEXT_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [3:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [16:0] token_length,
	output logic [1:0]  status,
	output logic [16:0] error_line,
	output logic [16:0] error_column,
	output logic        last_result
);

	logic             accept;
	logic             bundle_valid;
	stt_pkg::bundle_t bundle;
	stt_pkg::bundle_t head;
	logic             q_empty;
	logic             q_full;
	logic             deq;
	stt_pkg::result_t res;

	assign full   = q_full;
	assign accept = push && !q_full;

	stt_scanner #(
		.TEXT_BYTES(TEXT_BYTES)
	) u_scanner (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.bundle_valid(bundle_valid),
		.bundle      (bundle)
	);

	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (bundle_valid),
		.wr_data(bundle),
		.rd_en  (deq),
		.head   (head),
		.q_empty(q_empty),
		.q_full (q_full)
	);

	stt_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.deq        (deq),
		.pop        (pop),
		.empty      (empty),
		.res        (res),
		.last_result(last_result)
	);

	assign result_kind  = res.result_kind;
	assign token_kind   = res.token_kind;
	assign start_offset = res.start_offset;
	assign token_length = res.token_length;
	assign status       = res.status;
	assign error_line   = res.error_line;
	assign error_column = res.error_column;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Streams short source texts into the tokenizer and checks every token and
// end-of-run status against a cycle-free prediction of the scanner. Directed
// texts cover each token kind, the comment forms and every error. Random
// well-formed texts follow, with occasional noise. Both queue sides idle at
// random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		stt_pkg::result_t res;
		logic             last;
	} token_entry_t;

	class token_tracker;
		localparam logic [16:0] LENGTH_CAP = 17'h10000;
		localparam logic [15:0] OFFSET_CAP = 16'hFFFF;

		token_entry_t        tokens_due[$];
		stt_pkg::result_t    fresh[$];
		int                  errors;
		string               keyword_text = "function";
		stt_pkg::scan_mode_t mode;
		logic [3:0]          kw_count;
		logic [15:0]         tok_start;
		logic [15:0]         offset;
		logic [16:0]         tok_size;
		logic [16:0]         line;
		logic [16:0]         col;
		logic [16:0]         open_line;
		logic [16:0]         open_col;
		bit                  halted;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			mode = stt_pkg::SM_IDLE;
			kw_count = 4'd0;
			tok_start = 16'd0;
			tok_size = 17'd0;
			offset = 16'd0;
			line = 17'd1;
			col = 17'd1;
			open_line = 17'd1;
			open_col = 17'd1;
			halted = 1'b0;
		endfunction

		function int pending();
			return tokens_due.size();
		endfunction

		function bit numeral(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit alpha(logic [7:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function void emit_token(stt_pkg::tok_kind_t kind, logic [15:0] start,
				logic [16:0] len);
			stt_pkg::result_t r;
			r.result_kind = stt_pkg::RK_TOKEN;
			r.token_kind = kind;
			r.start_offset = start;
			r.token_length = len;
			r.status = stt_pkg::ST_OK;
			r.error_line = 17'd0;
			r.error_column = 17'd0;
			fresh.push_back(r);
		endfunction

		function void report(stt_pkg::status_t st, logic [16:0] ln, logic [16:0] cl);
			stt_pkg::result_t r;
			r.result_kind = stt_pkg::RK_STATUS;
			r.token_kind = stt_pkg::TK_KEYWORD;
			r.start_offset = 16'd0;
			r.token_length = 17'd0;
			r.status = st;
			r.error_line = ln;
			r.error_column = cl;
			fresh.push_back(r);
		endfunction

		function void raise_error(stt_pkg::status_t st, logic [16:0] ln, logic [16:0] cl);
			report(st, ln, cl);
			halted = 1'b1;
			mode = stt_pkg::SM_IDLE;
		endfunction

		function void grow();
			if (tok_size != LENGTH_CAP)
				tok_size++;
		endfunction

		function void start_token(logic [7:0] c);
			mode = stt_pkg::SM_IDLE;
			case (c)
				stt_pkg::CH_SPACE, stt_pkg::CH_NL: ;
				stt_pkg::CH_LBRACE: emit_token(stt_pkg::TK_LBRACE, offset, 17'd1);
				stt_pkg::CH_RBRACE: emit_token(stt_pkg::TK_RBRACE, offset, 17'd1);
				stt_pkg::CH_LPAREN: emit_token(stt_pkg::TK_LPAREN, offset, 17'd1);
				stt_pkg::CH_RPAREN: emit_token(stt_pkg::TK_RPAREN, offset, 17'd1);
				stt_pkg::CH_ASSIGN: emit_token(stt_pkg::TK_ASSIGN, offset, 17'd1);
				stt_pkg::CH_PLUS: emit_token(stt_pkg::TK_PLUS, offset, 17'd1);
				stt_pkg::CH_MINUS: emit_token(stt_pkg::TK_MINUS, offset, 17'd1);
				stt_pkg::CH_SLASH: begin
					mode = stt_pkg::SM_SLASH;
					open_line = line;
					open_col = col;
				end
				stt_pkg::CH_NUL: raise_error(stt_pkg::ST_NUL, line, col);
				default: begin
					if (numeral(c) || alpha(c)) begin
						tok_start = offset;
						tok_size = 17'd1;
						if (c == stt_pkg::CH_F) begin
							mode = stt_pkg::SM_KEY;
							kw_count = 4'd1;
						end else if (numeral(c)) begin
							mode = stt_pkg::SM_NUM;
						end else begin
							mode = stt_pkg::SM_IDENT;
						end
					end else begin
						raise_error(stt_pkg::ST_UNRECOGNIZED, line, col);
					end
				end
			endcase
		endfunction

		function void note_byte(logic [7:0] c, logic eot);
			if (halted) begin
				if (eot)
					clear();
				return;
			end
			case (mode)
				stt_pkg::SM_SLASH: begin
					if (c == stt_pkg::CH_SLASH)
						mode = stt_pkg::SM_LINE;
					else if (c == stt_pkg::CH_STAR)
						mode = stt_pkg::SM_BSTAR;
					else
						raise_error(stt_pkg::ST_UNRECOGNIZED, open_line, open_col);
				end
				stt_pkg::SM_LINE: begin
					if (c == stt_pkg::CH_NL)
						mode = stt_pkg::SM_IDLE;
				end
				stt_pkg::SM_BLOCK, stt_pkg::SM_BSTAR: begin
					if (mode == stt_pkg::SM_BSTAR && c == stt_pkg::CH_SLASH)
						mode = stt_pkg::SM_IDLE;
					else if (c == stt_pkg::CH_STAR)
						mode = stt_pkg::SM_BSTAR;
					else
						mode = stt_pkg::SM_BLOCK;
				end
				stt_pkg::SM_NUM: begin
					if (numeral(c)) begin
						grow();
					end else begin
						emit_token(stt_pkg::TK_NUMBER, tok_start, tok_size);
						start_token(c);
					end
				end
				stt_pkg::SM_IDENT: begin
					if (numeral(c) || alpha(c)) begin
						grow();
					end else begin
						emit_token(stt_pkg::TK_IDENT, tok_start, tok_size);
						start_token(c);
					end
				end
				stt_pkg::SM_KEY: begin
					if (kw_count < stt_pkg::KW_LEN && c == keyword_text[kw_count]) begin
						kw_count++;
						grow();
						if (kw_count == stt_pkg::KW_LEN) begin
							emit_token(stt_pkg::TK_KEYWORD, tok_start, tok_size);
							mode = stt_pkg::SM_IDLE;
						end
					end else if (numeral(c) || alpha(c)) begin
						grow();
						mode = stt_pkg::SM_IDENT;
					end else begin
						emit_token(stt_pkg::TK_IDENT, tok_start, tok_size);
						start_token(c);
					end
				end
				default: start_token(c);
			endcase

			if (offset != OFFSET_CAP)
				offset++;
			if (c == stt_pkg::CH_NL) begin
				if (line != stt_pkg::LC_MAX)
					line++;
				col = 17'd1;
			end else if (col != stt_pkg::LC_MAX) begin
				col++;
			end

			if (eot && !halted) begin
				if (mode == stt_pkg::SM_NUM)
					emit_token(stt_pkg::TK_NUMBER, tok_start, tok_size);
				else if (mode == stt_pkg::SM_IDENT || mode == stt_pkg::SM_KEY)
					emit_token(stt_pkg::TK_IDENT, tok_start, tok_size);
				if (mode == stt_pkg::SM_SLASH)
					raise_error(stt_pkg::ST_UNRECOGNIZED, open_line, open_col);
				else if (mode == stt_pkg::SM_BLOCK || mode == stt_pkg::SM_BSTAR)
					raise_error(stt_pkg::ST_UNCLOSED, open_line, open_col);
				else
					report(stt_pkg::ST_OK, 17'd0, 17'd0);
			end
			if (eot)
				clear();

			foreach (fresh[i])
				tokens_due.push_back({fresh[i], i == fresh.size() - 1});
			fresh.delete();
		endfunction

		function void compare(string name, logic [16:0] want, logic [16:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(stt_pkg::result_t got, logic got_last);
			token_entry_t want;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d token %0d",
					$time, got.result_kind, got.token_kind);
				errors++;
				return;
			end
			want = tokens_due.pop_front();
			compare("result_kind", want.res.result_kind, got.result_kind);
			compare("token_kind", want.res.token_kind, got.token_kind);
			compare("start_offset", want.res.start_offset, got.start_offset);
			compare("token_length", want.res.token_length, got.token_length);
			compare("status", want.res.status, got.status);
			compare("error_line", want.res.error_line, got.error_line);
			compare("error_column", want.res.error_column, got.error_column);
			compare("last_result", want.last, got_last);
		endfunction
	endclass

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BYTES = 55;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_text = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        result_kind;
	logic [3:0]  token_kind;
	logic [15:0] start_offset;
	logic [16:0] token_length;
	logic [1:0]  status;
	logic [16:0] error_line;
	logic [16:0] error_column;
	logic        last_result;

	token_tracker tracker = new();
	logic [7:0]   text_q[$];
	int           burst_left = 0;
	int           live_bytes = 0;
	int           quiet = 0;
	bit           hold_off = 1'b0;

	source_text_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.token_kind(token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.status(status),
		.error_line(error_line),
		.error_column(error_column),
		.last_result(last_result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				if (!tracker.halted)
					live_bytes++;
				tracker.note_byte(text_byte, end_of_text);
			end
			if (pop && !empty)
				tracker.check_result({result_kind, token_kind, start_offset, token_length,
					status, error_line, error_column}, last_result);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int recv_mode;
		int left;
		recv_mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
			if (left == 0) begin
				recv_mode = $urandom_range(0, 3);
				left = $urandom_range(20, 80);
			end
			left--;
			case (recv_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= (left % 4 != 0);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		do
			@(posedge clk);
		while (full !== 1'b0);
	endtask

	function automatic void add_byte(logic [7:0] b);
		text_q.push_back(b);
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 4) == 0)
			return stt_pkg::CH_F;
		return $urandom_range(0, 1) ? 8'(65 + $urandom_range(0, 25))
			: 8'(97 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return $urandom_range(0, 2) == 0 ? 8'(48 + $urandom_range(0, 9)) : rand_letter();
	endfunction

	// Block comment filler never contains the star, so it cannot close early.
	function automatic void add_filler(bit block);
		logic [7:0] b;
		repeat ($urandom_range(0, 6)) begin
			b = 8'($urandom_range(0, 255));
			while ((block && b == stt_pkg::CH_STAR) || (!block && b == stt_pkg::CH_NL))
				b = 8'($urandom_range(0, 255));
			text_q.push_back(b);
		end
	endfunction

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic random_text();
		int pieces;
		int noise_at;
		string kw;
		kw = "function";
		pieces = $urandom_range(1, 10);
		noise_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pieces - 1) : -1;
		for (int p = 0; p < pieces; p++) begin
			if (p == noise_at) begin
				case ($urandom_range(0, 3))
					0: add_byte(8'($urandom_range(0, 255)));
					1: add_byte(stt_pkg::CH_NUL);
					2: add_str("/ ");
					default: add_str("\t");
				endcase
			end
			case ($urandom_range(0, 12))
				0: add_str(kw);
				1: begin
					add_str(kw);
					add_byte(rand_alnum());
				end
				2: begin
					add_str(kw.substr(0, $urandom_range(0, 6)));
					if ($urandom_range(0, 1))
						add_byte(rand_alnum());
				end
				3, 4: begin
					add_byte(rand_letter());
					repeat ($urandom_range(0, 5)) add_byte(rand_alnum());
				end
				5: repeat ($urandom_range(1, 5)) add_byte(8'(48 + $urandom_range(0, 9)));
				6, 7, 8: begin
					case ($urandom_range(0, 6))
						0: add_byte(stt_pkg::CH_LBRACE);
						1: add_byte(stt_pkg::CH_RBRACE);
						2: add_byte(stt_pkg::CH_LPAREN);
						3: add_byte(stt_pkg::CH_RPAREN);
						4: add_byte(stt_pkg::CH_ASSIGN);
						5: add_byte(stt_pkg::CH_PLUS);
						default: add_byte(stt_pkg::CH_MINUS);
					endcase
				end
				9: add_byte(stt_pkg::CH_NL);
				10: begin
					add_str("//");
					add_filler(1'b0);
					add_byte(stt_pkg::CH_NL);
				end
				11: begin
					add_str("/*");
					add_filler(1'b1);
					repeat ($urandom_range(1, 3)) add_byte(stt_pkg::CH_STAR);
					add_byte(stt_pkg::CH_SLASH);
				end
				default: add_str("/*/");
			endcase
			if ($urandom_range(0, 1))
				add_byte($urandom_range(0, 2) == 0 ? stt_pkg::CH_NL : stt_pkg::CH_SPACE);
		end
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1)) begin
				add_str("/*");
				add_filler(1'b1);
			end else begin
				add_byte(stt_pkg::CH_SLASH);
			end
		end
	endtask

	initial begin
		int base;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_str("function");
		send_text();
		add_str("functionx{}()=+-");
		send_text();
		add_str("functionfunction func");
		send_text();
		add_str("fun1 ffunction functio(");
		send_text();
		add_str("12 ab9\nZz0 f");
		send_text();
		add_str("x // note");
		send_text();
		add_str("a/*/b /* y **/c");
		send_text();
		add_str("1\n  /* open");
		send_text();
		add_str("a / b");
		send_text();
		add_str("x/");
		send_text();
		add_str("//");
		send_text();
		add_str("q/*");
		send_text();
		add_str("ab");
		add_byte(stt_pkg::CH_NUL);
		add_str("cd");
		send_text();
		add_str("/*");
		add_byte(stt_pkg::CH_NUL);
		add_byte(8'hFF);
		add_str("*/z");
		send_text();
		add_str("q\tr");
		send_text();
		add_byte(8'hFF);
		send_text();
		add_byte(8'h80);
		add_byte(8'h7F);
		send_text();
		add_str("}");
		send_text();
		add_str(" ");
		send_text();
		add_str("9");
		send_text();
		add_str("f");
		send_text();

		hold_off = 1'b1;
		base = live_bytes;
		while (live_bytes - base < RANDOM_BYTES) begin
			random_text();
			send_text();
		end

		@(negedge clk);
		push <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
